// ----- hw/rtl/i2cmbe_pkg.sv -----
// Shared types and constants of the I2C master byte engine.
// Used by every RTL module of the block; depends on nothing.
`timescale 1ns / 1ps

package i2cmbe_pkg;

  typedef enum logic [1:0] {
    CmdStart = 2'd0,
    CmdStop  = 2'd1,
    CmdWrite = 2'd2,
    CmdRead  = 2'd3
  } cmd_kind_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StBusy   = 2'd1,
    StBusErr = 2'd2,
    StNoAck  = 2'd3
  } status_e;

  typedef enum logic {
    SeqIdle = 1'b0,
    SeqRun  = 1'b1
  } seq_state_e;

  localparam int unsigned PhaseIdxW = 5;

  // Index of the final phase of each command run.
  localparam logic [PhaseIdxW-1:0] StartBusyLastIdx = 5'd0;
  localparam logic [PhaseIdxW-1:0] StartErrLastIdx  = 5'd1;
  localparam logic [PhaseIdxW-1:0] StartLastIdx     = 5'd4;
  localparam logic [PhaseIdxW-1:0] StopLastIdx      = 5'd4;
  localparam logic [PhaseIdxW-1:0] WriteLastIdx     = 5'd28;
  localparam logic [PhaseIdxW-1:0] ReadLastIdx      = 5'd21;
  // Phases spent shifting out the eight data bits of a write.
  localparam logic [PhaseIdxW-1:0] WriteBitPhases   = 5'd24;
  // Last phase of the eight clocked data bits of a read.
  localparam logic [PhaseIdxW-1:0] ReadBitLastIdx   = 5'd16;

  localparam int unsigned FifoDepthDefault = 2;
  localparam logic [15:0] TicksReset       = 16'd100;

  // One classified command as it travels from the front to the back.
  typedef struct packed {
    cmd_kind_e             kind;
    logic [7:0]            tx_byte;
    logic                  send_nack;
    logic [PhaseIdxW-1:0]  last_idx;
    status_e               status;
    logic [7:0]            rx_byte;
  } cmd_t;

  // Line levels and hold time of one bus phase.
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [2:0] hold;
  } phase_t;

endpackage

// ----- hw/rtl/i2cmbe_front.sv -----
// Front end of the I2C master byte engine: accepts commands and classifies them.
// Depends on i2cmbe_pkg.
`timescale 1ns / 1ps

module i2cmbe_front (
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [23:0]        s_axis_tdata_i,
  input  logic [1:0]         s_axis_tuser_i,
  input  logic               fifo_full_i,
  output logic               push_o,
  output i2cmbe_pkg::cmd_t   cmd_o
);

  i2cmbe_pkg::cmd_kind_e kind;
  logic [7:0]            tx_byte;
  logic                  send_nack;
  logic [7:0]            samples;

  assign kind      = i2cmbe_pkg::cmd_kind_e'(s_axis_tuser_i);
  assign tx_byte   = s_axis_tdata_i[7:0];
  assign send_nack = s_axis_tdata_i[8];
  assign samples   = s_axis_tdata_i[16:9];

  assign s_axis_tready_o = !fifo_full_i;
  assign push_o          = s_axis_tvalid_i && !fifo_full_i;

  // The outcome of every command is known from its samples up front, so the
  // run length and final status are settled here.
  always_comb begin
    cmd_o.kind      = kind;
    cmd_o.tx_byte   = tx_byte;
    cmd_o.send_nack = send_nack;
    cmd_o.rx_byte   = 8'd0;
    cmd_o.status    = i2cmbe_pkg::StOk;
    cmd_o.last_idx  = i2cmbe_pkg::StopLastIdx;
    unique case (kind)
      i2cmbe_pkg::CmdStart: begin
        if (!samples[7]) begin
          cmd_o.last_idx = i2cmbe_pkg::StartBusyLastIdx;
          cmd_o.status   = i2cmbe_pkg::StBusy;
        end else if (samples[6]) begin
          cmd_o.last_idx = i2cmbe_pkg::StartErrLastIdx;
          cmd_o.status   = i2cmbe_pkg::StBusErr;
        end else begin
          cmd_o.last_idx = i2cmbe_pkg::StartLastIdx;
        end
      end
      i2cmbe_pkg::CmdStop: begin
        cmd_o.last_idx = i2cmbe_pkg::StopLastIdx;
      end
      i2cmbe_pkg::CmdWrite: begin
        cmd_o.last_idx = i2cmbe_pkg::WriteLastIdx;
        cmd_o.status   = samples[7] ? i2cmbe_pkg::StNoAck : i2cmbe_pkg::StOk;
      end
      i2cmbe_pkg::CmdRead: begin
        cmd_o.last_idx = i2cmbe_pkg::ReadLastIdx;
        cmd_o.rx_byte  = samples;
      end
      default: begin
        cmd_o.last_idx = i2cmbe_pkg::StopLastIdx;
      end
    endcase
  end

endmodule

// ----- hw/rtl/i2cmbe_fifo.sv -----
// Short command queue between front and back of the I2C master byte engine.
// Depends on i2cmbe_pkg.
`timescale 1ns / 1ps

module i2cmbe_fifo #(
  parameter int unsigned Depth = i2cmbe_pkg::FifoDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  i2cmbe_pkg::cmd_t wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output i2cmbe_pkg::cmd_t rdata_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  i2cmbe_pkg::cmd_t mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- hw/rtl/i2cmbe_back.sv -----
// Back end of the I2C master byte engine: steps each command through its bus phases.
// Depends on i2cmbe_pkg; fed by i2cmbe_fifo.
`timescale 1ns / 1ps

module i2cmbe_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fifo_valid_i,
  input  i2cmbe_pkg::cmd_t fifo_cmd_i,
  output logic             pop_o,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,
  output logic             m_axis_tlast_o,
  output logic [1:0]       m_axis_tuser_o
);

  localparam int unsigned IdxW = i2cmbe_pkg::PhaseIdxW;

  i2cmbe_pkg::seq_state_e state_q, state_d;
  i2cmbe_pkg::cmd_t       cmd_q;
  logic [IdxW-1:0]        idx_q;
  logic [1:0]             sub_q;
  logic [7:0]             sh_q;
  logic                   scl_q, sda_q;

  logic                   out_valid_q;
  i2cmbe_pkg::phase_t     out_phase_q;
  logic                   out_last_q;
  logic [1:0]             out_status_q;
  logic [7:0]             out_rx_q;

  i2cmbe_pkg::phase_t     phase;
  logic                   emit, is_last, pop;
  logic                   write_bits;

  assign is_last    = (idx_q == cmd_q.last_idx);
  assign write_bits = (idx_q < i2cmbe_pkg::WriteBitPhases);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      i2cmbe_pkg::SeqIdle: begin
        if (pop) state_d = i2cmbe_pkg::SeqRun;
      end
      i2cmbe_pkg::SeqRun: begin
        if (emit && is_last && !pop) state_d = i2cmbe_pkg::SeqIdle;
      end
      default: state_d = i2cmbe_pkg::SeqIdle;
    endcase
  end

  // Outputs of the sequencer: emit a phase when the output slot frees up, and
  // take the next command as the current one hands out its last phase.
  always_comb begin
    emit = 1'b0;
    pop  = 1'b0;
    unique case (state_q)
      i2cmbe_pkg::SeqIdle: begin
        pop = fifo_valid_i;
      end
      i2cmbe_pkg::SeqRun: begin
        emit = !out_valid_q || m_axis_tready_i;
        pop  = fifo_valid_i && emit && is_last;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign pop_o = pop;

  // Phase generator. The current line levels stand in for the levels the
  // previous phase left.
  always_comb begin
    phase = '{scl: 1'b0, sda: 1'b1, hold: 3'd0};
    unique case (cmd_q.kind)
      i2cmbe_pkg::CmdStart: begin
        case (idx_q)
          5'd0:    phase = '{scl: 1'b1, sda: 1'b1, hold: 3'd4};
          5'd1:    phase = '{scl: 1'b1, sda: 1'b0, hold: 3'd1};
          5'd2:    phase = '{scl: 1'b1, sda: 1'b0, hold: 3'd4};
          5'd3:    phase = '{scl: 1'b0, sda: 1'b0, hold: 3'd0};
          default: phase = '{scl: 1'b0, sda: 1'b1, hold: 3'd0};
        endcase
      end
      i2cmbe_pkg::CmdStop: begin
        case (idx_q)
          5'd0:    phase = '{scl: 1'b0, sda: sda_q, hold: 3'd1};
          5'd1:    phase = '{scl: 1'b0, sda: 1'b0,  hold: 3'd4};
          5'd2:    phase = '{scl: 1'b1, sda: 1'b0,  hold: 3'd1};
          5'd3:    phase = '{scl: 1'b1, sda: 1'b1,  hold: 3'd1};
          default: phase = '{scl: 1'b0, sda: 1'b1,  hold: 3'd0};
        endcase
      end
      i2cmbe_pkg::CmdWrite: begin
        if (write_bits) begin
          case (sub_q)
            2'd0:    phase = '{scl: 1'b0, sda: sda_q,    hold: 3'd1};
            2'd1:    phase = '{scl: 1'b0, sda: sh_q[7], hold: 3'd1};
            default: phase = '{scl: 1'b1, sda: sh_q[7], hold: 3'd1};
          endcase
        end else begin
          case (idx_q)
            5'd24:   phase = '{scl: 1'b0, sda: sda_q, hold: 3'd0};
            5'd25:   phase = '{scl: 1'b0, sda: sda_q, hold: 3'd1};
            5'd26:   phase = '{scl: 1'b0, sda: 1'b1,  hold: 3'd1};
            5'd27:   phase = '{scl: 1'b1, sda: 1'b1,  hold: 3'd1};
            default: phase = '{scl: 1'b0, sda: 1'b1,  hold: 3'd0};
          endcase
        end
      end
      i2cmbe_pkg::CmdRead: begin
        if (idx_q == '0) begin
          phase = '{scl: scl_q, sda: 1'b1, hold: 3'd0};
        end else if (idx_q <= i2cmbe_pkg::ReadBitLastIdx) begin
          // Odd phases drop SCL, even phases raise it for the sample.
          phase = '{scl: !idx_q[0], sda: 1'b1, hold: 3'd1};
        end else begin
          case (idx_q)
            5'd17:   phase = '{scl: 1'b0, sda: 1'b1,            hold: 3'd0};
            5'd18:   phase = '{scl: 1'b0, sda: 1'b1,            hold: 3'd1};
            5'd19:   phase = '{scl: 1'b0, sda: cmd_q.send_nack, hold: 3'd1};
            5'd20:   phase = '{scl: 1'b1, sda: cmd_q.send_nack, hold: 3'd1};
            default: phase = '{scl: 1'b0, sda: cmd_q.send_nack, hold: 3'd1};
          endcase
        end
      end
      default: begin
        phase = '{scl: 1'b0, sda: 1'b1, hold: 3'd0};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= i2cmbe_pkg::SeqIdle;
      out_valid_q <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      idx_q       <= '0;
      sub_q       <= '0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (emit) begin
        scl_q <= phase.scl;
        sda_q <= phase.sda;
      end
      if (pop) begin
        idx_q <= '0;
        sub_q <= '0;
      end else if (emit) begin
        idx_q <= idx_q + 1'b1;
        if (cmd_q.kind == i2cmbe_pkg::CmdWrite && write_bits) begin
          sub_q <= (sub_q == 2'd2) ? 2'd0 : sub_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cmd_q <= fifo_cmd_i;
      sh_q  <= fifo_cmd_i.tx_byte;
    end else if (emit && cmd_q.kind == i2cmbe_pkg::CmdWrite && write_bits &&
                 sub_q == 2'd2) begin
      sh_q <= {sh_q[6:0], 1'b0};
    end
    if (emit) begin
      out_phase_q  <= phase;
      out_last_q   <= is_last;
      out_status_q <= is_last ? cmd_q.status : i2cmbe_pkg::StOk;
      out_rx_q     <= is_last ? cmd_q.rx_byte : 8'd0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'd0, out_rx_q, out_phase_q.hold, out_phase_q.sda,
                            out_phase_q.scl};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_status_q;

endmodule

// ----- hw/rtl/i2c_master_byte_engine_unit.sv -----
// An accepted command is written into the command queue, taken into the back-end sequencer and
// sent out phase by phase through its output register. Throughput: one bus phase per cycle while
// the receiver is ready; start 1, 2 or 5 phases, stop 5, write byte 29, read byte 22.
// The command queue lets the next commands be accepted while a run is still being emitted.
// Reset (rst_ni, asynchronous, active low) empties the queue and the output register,
// releases both bus lines (SCL and SDA at 1) and sets the delay-unit register to 100 ticks.
`timescale 1ns / 1ps

// Top level of the I2C master byte engine.
// Depends on i2cmbe_pkg, i2cmbe_front, i2cmbe_fifo and i2cmbe_back.

module i2c_master_byte_engine_unit #(
  parameter int unsigned FifoDepth = i2cmbe_pkg::FifoDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: ticks per delay unit.
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // Command requests.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata from bit 0: tx_byte[7:0], send_nack[8], bus_sda_samples[16:9], zeros above.
  input  logic [23:0] s_axis_tdata_i,
  // tuser from bit 0: kind[1:0].
  input  logic [1:0]  s_axis_tuser_i,
  // Bus phase requests.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata from bit 0: scl_level[0], sda_drive[1], hold_units[4:2], rx_byte[12:5], zeros above.
  output logic [15:0] m_axis_tdata_o,
  // tlast marks the final phase of a command.
  output logic        m_axis_tlast_o,
  // tuser from bit 0: status[1:0].
  output logic [1:0]  m_axis_tuser_o
);

  // The delay-unit length is held here but drives no port of this block;
  // the phase values themselves carry the hold in units only.
  logic [15:0] ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= i2cmbe_pkg::TicksReset;
    end else if (cfg_we_i) begin
      ticks_q <= cfg_wdata_i;
    end
  end

  logic             push, fifo_full, fifo_valid, pop;
  i2cmbe_pkg::cmd_t push_cmd, head_cmd;

  // The front settles each command's run length and final status from its
  // samples, so the back only has to count phases.
  i2cmbe_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .fifo_full_i     (fifo_full),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  i2cmbe_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .rdata_o (head_cmd)
  );

  // The back keeps the line levels left by the last phase, since a stop, a
  // write and a read all start from where the previous command ended.
  i2cmbe_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fifo_valid_i    (fifo_valid),
    .fifo_cmd_i      (head_cmd),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

// ----- hw/rtl/i2cmbe_checker.sv -----
// Port-level checks for the I2C master byte engine, bound to its top level.
// Depends on i2cmbe_pkg and i2c_master_byte_engine_unit.
`timescale 1ns / 1ps

module i2cmbe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o,
  input logic [1:0]  m_axis_tuser_o
);

  // A stalled phase request keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) &&
      $stable(m_axis_tuser_o))
  else $error("stalled phase changed");

  // Status and received byte show only on the final phase of a command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |->
      m_axis_tuser_o == i2cmbe_pkg::StOk && m_axis_tdata_o[12:5] == 8'd0)
  else $error("status or data on an inner phase");

  // Hold time never exceeds four delay units.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[4:2] <= 3'd4)
  else $error("hold time out of range");

  // A busy bus ends the start on its first phase with both lines released.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o && m_axis_tuser_o == i2cmbe_pkg::StBusy |->
      m_axis_tdata_o[4:0] == 5'b10011)
  else $error("bus busy phase has wrong lines");

endmodule

bind i2c_master_byte_engine_unit i2cmbe_checker u_checker (.*);

// ----- sim/i2c_master_byte_engine_unit_test.sv -----
// Self-checking testbench for the I2C master byte engine: drives command requests,
// predicts every bus phase request and compares them field by field.
// Depends on i2cmbe_pkg and i2c_master_byte_engine_unit.
`timescale 1ns / 1ps

module i2c_master_byte_engine_unit_test;

  // One expected or observed bus phase request.
  typedef struct packed {
    logic                scl;
    logic                sda;
    logic [2:0]          hold;
    logic                last;
    i2cmbe_pkg::status_e status;
    logic [7:0]          rx;
  } bus_phase_t;

  // Predicts the phase runs of each accepted command and checks the phases that
  // come out of the block against them, oldest first.
  class bus_phase_scoreboard;
    bus_phase_t  expected_phases[$];
    logic        line_scl;
    logic        line_sda;
    logic [15:0] ticks_per_unit;
    int unsigned errors;
    int unsigned phases_seen;

    function new();
      line_scl       = 1'b1;
      line_sda       = 1'b1;
      ticks_per_unit = i2cmbe_pkg::TicksReset;
      errors         = 0;
      phases_seen    = 0;
    endfunction

    // The delay-unit length is kept for completeness; no phase field depends on it.
    function void note_ticks(logic [15:0] value);
      ticks_per_unit = value;
    endfunction

    function int unsigned pending();
      return expected_phases.size();
    endfunction

    // Appends one phase and moves the line levels the master leaves behind.
    function void push_phase(logic scl, logic sda, logic [2:0] hold, logic fin,
                             i2cmbe_pkg::status_e st, logic [7:0] rx);
      bus_phase_t p;
      line_scl = scl;
      line_sda = sda;
      p.scl    = scl;
      p.sda    = sda;
      p.hold   = hold;
      p.last   = fin;
      p.status = fin ? st : i2cmbe_pkg::StOk;
      p.rx     = fin ? rx : 8'h00;
      expected_phases.push_back(p);
    endfunction

    function void note_command(i2cmbe_pkg::cmd_kind_e kind, logic [7:0] tx, logic nack,
                               logic [7:0] samples);
      case (kind)
        i2cmbe_pkg::CmdStart: begin
          // A low idle sample means another master owns the bus.
          if (!samples[7]) begin
            push_phase(1'b1, 1'b1, 3'd4, 1'b1, i2cmbe_pkg::StBusy, 8'h00);
          end else begin
            push_phase(1'b1, 1'b1, 3'd4, 1'b0, i2cmbe_pkg::StOk, 8'h00);
            // SDA that stays high after the master pulled it low is a bus error.
            if (samples[6]) begin
              push_phase(1'b1, 1'b0, 3'd1, 1'b1, i2cmbe_pkg::StBusErr, 8'h00);
            end else begin
              push_phase(1'b1, 1'b0, 3'd1, 1'b0, i2cmbe_pkg::StOk, 8'h00);
              push_phase(1'b1, 1'b0, 3'd4, 1'b0, i2cmbe_pkg::StOk, 8'h00);
              push_phase(1'b0, 1'b0, 3'd0, 1'b0, i2cmbe_pkg::StOk, 8'h00);
              push_phase(1'b0, 1'b1, 3'd0, 1'b1, i2cmbe_pkg::StOk, 8'h00);
            end
          end
        end
        i2cmbe_pkg::CmdStop: begin
          push_phase(1'b0, line_sda, 3'd1, 1'b0, i2cmbe_pkg::StOk, 8'h00);
          push_phase(1'b0, 1'b0, 3'd4, 1'b0, i2cmbe_pkg::StOk, 8'h00);
          push_phase(1'b1, 1'b0, 3'd1, 1'b0, i2cmbe_pkg::StOk, 8'h00);
          push_phase(1'b1, 1'b1, 3'd1, 1'b0, i2cmbe_pkg::StOk, 8'h00);
          push_phase(1'b0, 1'b1, 3'd0, 1'b1, i2cmbe_pkg::StOk, 8'h00);
        end
        i2cmbe_pkg::CmdWrite: begin
          for (int k = 7; k >= 0; k--) begin
            push_phase(1'b0, line_sda, 3'd1, 1'b0, i2cmbe_pkg::StOk, 8'h00);
            push_phase(1'b0, tx[k], 3'd1, 1'b0, i2cmbe_pkg::StOk, 8'h00);
            push_phase(1'b1, tx[k], 3'd1, 1'b0, i2cmbe_pkg::StOk, 8'h00);
          end
          push_phase(1'b0, line_sda, 3'd0, 1'b0, i2cmbe_pkg::StOk, 8'h00);
          push_phase(1'b0, line_sda, 3'd1, 1'b0, i2cmbe_pkg::StOk, 8'h00);
          push_phase(1'b0, 1'b1, 3'd1, 1'b0, i2cmbe_pkg::StOk, 8'h00);
          push_phase(1'b1, 1'b1, 3'd1, 1'b0, i2cmbe_pkg::StOk, 8'h00);
          push_phase(1'b0, 1'b1, 3'd0, 1'b1,
                     samples[7] ? i2cmbe_pkg::StNoAck : i2cmbe_pkg::StOk, 8'h00);
        end
        default: begin
          push_phase(line_scl, 1'b1, 3'd0, 1'b0, i2cmbe_pkg::StOk, 8'h00);
          repeat (8) begin
            push_phase(1'b0, 1'b1, 3'd1, 1'b0, i2cmbe_pkg::StOk, 8'h00);
            push_phase(1'b1, 1'b1, 3'd1, 1'b0, i2cmbe_pkg::StOk, 8'h00);
          end
          push_phase(1'b0, 1'b1, 3'd0, 1'b0, i2cmbe_pkg::StOk, 8'h00);
          push_phase(1'b0, 1'b1, 3'd1, 1'b0, i2cmbe_pkg::StOk, 8'h00);
          push_phase(1'b0, nack, 3'd1, 1'b0, i2cmbe_pkg::StOk, 8'h00);
          push_phase(1'b1, nack, 3'd1, 1'b0, i2cmbe_pkg::StOk, 8'h00);
          push_phase(1'b0, nack, 3'd1, 1'b1, i2cmbe_pkg::StOk, samples);
        end
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want != got) begin
        errors++;
        $display("%0t: phase %0d field %s: expected %0h, actual %0h",
                 $time, phases_seen, name, want, got);
      end
    endfunction

    function void check_phase(bus_phase_t got);
      bus_phase_t want;
      phases_seen++;
      if (expected_phases.size() == 0) begin
        errors++;
        $display("%0t: phase %0d arrived with none expected, expected none, actual %0h",
                 $time, phases_seen, got);
      end else begin
        want = expected_phases.pop_front();
        compare_field("scl_level", 8'(want.scl), 8'(got.scl));
        compare_field("sda_drive", 8'(want.sda), 8'(got.sda));
        compare_field("hold_units", 8'(want.hold), 8'(got.hold));
        compare_field("last", 8'(want.last), 8'(got.last));
        compare_field("status", 8'(want.status), 8'(got.status));
        compare_field("rx_byte", want.rx, got.rx);
      end
    endfunction
  endclass

  // Clock, reset and every block input start at known values.
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [15:0] cfg_wdata  = 16'h0000;
  logic        cmd_tvalid = 1'b0;
  logic [23:0] cmd_tdata  = 24'h000000;
  logic [1:0]  cmd_tuser  = 2'b00;
  logic        phase_tready = 1'b0;

  logic        cmd_tready;
  logic        phase_tvalid;
  logic [15:0] phase_tdata;
  logic        phase_tlast;
  logic [1:0]  phase_tuser;

  bus_phase_scoreboard sb;
  int unsigned commands_sent;
  int unsigned burst_left;

  i2c_master_byte_engine_unit i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (cmd_tvalid),
    .s_axis_tready_o (cmd_tready),
    .s_axis_tdata_i  (cmd_tdata),
    .s_axis_tuser_i  (cmd_tuser),
    .m_axis_tvalid_o (phase_tvalid),
    .m_axis_tready_i (phase_tready),
    .m_axis_tdata_o  (phase_tdata),
    .m_axis_tlast_o  (phase_tlast),
    .m_axis_tuser_o  (phase_tuser)
  );

  // 50 MHz clock: 10 ns high, 10 ns low.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver follows a rotating 16-bit ready mask that is reloaded now and then.
  // A mask of all ones gives stretches without stalls; the low bit is always set so
  // that every mask holds at least one ready bit and no stall lasts forever.
  logic [15:0] ready_mask = 16'hFFFF;
  int          mask_age   = 0;

  always @(posedge clk) begin
    if (mask_age == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_mask = 16'hFFFF;
        1:       ready_mask = 16'($urandom & $urandom) | 16'h0001;
        default: ready_mask = 16'($urandom) | 16'h0001;
      endcase
      mask_age = int'($urandom_range(20, 120));
    end else begin
      mask_age--;
    end
    phase_tready <= ready_mask[0];
    ready_mask = {ready_mask[0], ready_mask[15:1]};
  end

  // Output monitor. Signals read right after the edge still hold their values from
  // before it, so a handshake seen here is the one that completes at this edge.
  always @(posedge clk) begin
    bus_phase_t got;
    if (rst_n && phase_tvalid && phase_tready) begin
      got.scl    = phase_tdata[0];
      got.sda    = phase_tdata[1];
      got.hold   = phase_tdata[4:2];
      got.rx     = phase_tdata[12:5];
      got.last   = phase_tlast;
      got.status = i2cmbe_pkg::status_e'(phase_tuser);
      sb.check_phase(got);
    end
  end

  // Offers one command request and waits for it to be taken. The sender works in
  // bursts; between bursts valid may drop for a random pause, or not at all.
  task automatic send_command(i2cmbe_pkg::cmd_kind_e kind, logic [7:0] tx, logic nack,
                              logic [7:0] samples);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        cmd_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    cmd_tvalid <= 1'b1;
    cmd_tuser  <= kind;
    cmd_tdata  <= {7'b0, samples, nack, tx};
    do @(posedge clk); while (!cmd_tready);
    sb.note_command(kind, tx, nack, samples);
    commands_sent++;
    burst_left--;
  endtask

  // Drops valid and waits until every expected phase is out, then lets the
  // pipeline settle so that a register write meets an idle block.
  task automatic drain_phases();
    cmd_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_ticks(logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.note_ticks(value);
  endtask

  // Short directed run: all command kinds, both ack and nack, the bus busy and
  // bus error starts, a write without ack, and commands given out of order so
  // that stop and read start from the line levels those cases leave behind.
  task automatic run_directed();
    send_command(i2cmbe_pkg::CmdStart, 8'hFF, 1'b1, 8'h80);
    send_command(i2cmbe_pkg::CmdWrite, 8'h00, 1'b0, 8'h00);
    send_command(i2cmbe_pkg::CmdWrite, 8'hFF, 1'b1, 8'h80);
    send_command(i2cmbe_pkg::CmdRead,  8'h00, 1'b0, 8'h00);
    send_command(i2cmbe_pkg::CmdRead,  8'hFF, 1'b1, 8'hFF);
    send_command(i2cmbe_pkg::CmdStop,  8'h00, 1'b0, 8'h00);
    send_command(i2cmbe_pkg::CmdStart, 8'h3C, 1'b0, 8'h7F);
    send_command(i2cmbe_pkg::CmdRead,  8'h00, 1'b1, 8'hA5);
    send_command(i2cmbe_pkg::CmdStart, 8'h00, 1'b0, 8'hC0);
    send_command(i2cmbe_pkg::CmdStop,  8'hFF, 1'b1, 8'hFF);
    send_command(i2cmbe_pkg::CmdWrite, 8'hA5, 1'b0, 8'h7F);
    send_command(i2cmbe_pkg::CmdRead,  8'h00, 1'b0, 8'h5A);
    send_command(i2cmbe_pkg::CmdStart, 8'h00, 1'b0, 8'h00);
    send_command(i2cmbe_pkg::CmdStop,  8'h00, 1'b0, 8'h00);
    send_command(i2cmbe_pkg::CmdStart, 8'h81, 1'b1, 8'hBF);
    send_command(i2cmbe_pkg::CmdWrite, 8'h5A, 1'b0, 8'h01);
    send_command(i2cmbe_pkg::CmdWrite, 8'h80, 1'b1, 8'hFF);
    send_command(i2cmbe_pkg::CmdStop,  8'h00, 1'b0, 8'h00);
  endtask

  // Mostly well-formed transfers (start, a few byte commands, stop) with random
  // content; the rest is loose commands in any order with random samples.
  task automatic run_random(int unsigned upto);
    logic [7:0] smp;
    while (commands_sent < upto) begin
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 4)) begin
          send_command(i2cmbe_pkg::cmd_kind_e'($urandom_range(0, 3)), 8'($urandom),
                       1'($urandom_range(0, 1)), 8'($urandom));
        end
      end else begin
        smp    = 8'($urandom);
        smp[7] = ($urandom_range(0, 9) != 0);
        smp[6] = ($urandom_range(0, 9) == 0);
        send_command(i2cmbe_pkg::CmdStart, 8'($urandom), 1'($urandom_range(0, 1)), smp);
        repeat ($urandom_range(1, 4)) begin
          smp = 8'($urandom);
          if ($urandom_range(0, 1) == 1) begin
            // Mostly acknowledged bytes, sometimes a missing ack.
            smp[7] = ($urandom_range(0, 4) == 0);
            send_command(i2cmbe_pkg::CmdWrite, 8'($urandom), 1'($urandom_range(0, 1)),
                         smp);
          end else begin
            send_command(i2cmbe_pkg::CmdRead, 8'($urandom), 1'($urandom_range(0, 1)),
                         smp);
          end
        end
        send_command(i2cmbe_pkg::CmdStop, 8'($urandom), 1'($urandom_range(0, 1)),
                     8'($urandom));
      end
    end
  endtask

  // Main sequence: reset once, then four phases, each with its own delay-unit
  // setting (smallest, largest, reset value, random) written while idle.
  initial begin
    sb            = new();
    commands_sent = 0;
    burst_left    = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_ticks(16'd1);
    run_directed();
    drain_phases();

    write_ticks(16'hFFFF);
    run_random(90);
    drain_phases();

    write_ticks(i2cmbe_pkg::TicksReset);
    run_random(150);
    drain_phases();

    write_ticks(16'($urandom_range(1, 65535)));
    run_random(210);
    drain_phases();

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // A correct run needs about 2 ms even with the longest stalls; allow ten times that.
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
